### rtl/core/psrf_pkg.sv
package psrf_pkg;

    // Field widths of one input word and one result word.
    localparam int SENDER_W   = 8;
    localparam int SEQ_W      = 32;
    localparam int TICK_W     = 48;
    localparam int MIN_INT_W  = 16;
    localparam int VERDICT_W  = 3;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    // Number of distinct sender indexes the input field can carry.
    localparam int SENDER_COUNT = 2 ** SENDER_W;

    localparam int MAX_SENDERS_DEFAULT = 256;

    localparam logic [MIN_INT_W-1:0] MIN_INTERVAL_RESET = 16'd900;

    // Item kinds carried on the mode field.
    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_LEAVE  = 1'b1;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_RELAYED  = 3'd0,
        VERDICT_NO_CAP   = 3'd1,
        VERDICT_ZERO_SEQ = 3'd2,
        VERDICT_STALE    = 3'd3,
        VERDICT_TOO_SOON = 3'd4,
        VERDICT_LEAVE    = 3'd5
    } verdict_t;

    // One table entry as seen by the check logic; an invalid entry reads as zero.
    typedef struct packed {
        logic             valid;
        logic [SEQ_W-1:0]  seq;
        logic [TICK_W-1:0] tick;
    } entry_t;

endpackage

### rtl/core/psrf_check.sv
// Decides the verdict for one item from its fields and the sender's table entry.
module psrf_check
(
    input  logic                              leave,
    input  logic                              has_capability,
    input  logic [psrf_pkg::SEQ_W-1:0]        sequence_req,
    input  logic [psrf_pkg::TICK_W-1:0]       now_tick,
    input  psrf_pkg::entry_t                  entry,
    input  logic [psrf_pkg::MIN_INT_W-1:0]    min_interval,
    output psrf_pkg::verdict_t                verdict
);

    logic [psrf_pkg::SEQ_W-1:0]  seq_diff;
    logic                        seq_newer;
    logic [psrf_pkg::TICK_W-1:0] tick_diff;
    logic                        too_soon;

    // Serial-number compare: the new sequence is ahead when the wrapped
    // difference is nonzero and has its sign bit clear.
    assign seq_diff  = sequence_req - entry.seq;
    assign seq_newer = (seq_diff != '0) && !seq_diff[psrf_pkg::SEQ_W-1];

    // A clock that moved backwards never counts as too soon.
    assign tick_diff = now_tick - entry.tick;
    assign too_soon  = (entry.tick != '0) && (now_tick >= entry.tick)
                     && (tick_diff < psrf_pkg::TICK_W'(min_interval));

    always_comb
    begin
        priority if (leave)
        begin
            verdict = psrf_pkg::VERDICT_LEAVE;
        end
        else if (!has_capability)
        begin
            verdict = psrf_pkg::VERDICT_NO_CAP;
        end
        else if (sequence_req == '0)
        begin
            verdict = psrf_pkg::VERDICT_ZERO_SEQ;
        end
        else if (entry.valid && !seq_newer)
        begin
            verdict = psrf_pkg::VERDICT_STALE;
        end
        else if (too_soon)
        begin
            verdict = psrf_pkg::VERDICT_TOO_SOON;
        end
        else
        begin
            verdict = psrf_pkg::VERDICT_RELAYED;
        end
    end

endmodule

### rtl/core/per_sender_sequence_rate_filter.sv
// Channel   | Handshake                      | Words carried
// ----------+--------------------------------+---------------------------------------------
// input     | start, busy (busy is held low) | mode, sender_index, has_capability,
//           |                                | sequence_req, now_tick
// result    | done (one-cycle strobe)        | relay, verdict, sender_out
// config    | APB: psel, penable, pwrite,    | min_interval_ms at byte address 0
//           | paddr, pwdata, prdata, pready  |
//
// A new input word is taken in every clock cycle, and each one gives exactly one
// result word. Between the accepting edge and done lie the registered read of the
// sender table and the result register behind the check logic.
// Reset clears the control state and the table's valid bits and loads the interval
// register with its reset value at once, so there is no clearing pass and the block is usable right after reset.
// The receiver cannot stall the result channel, so nothing inside ever waits.
module per_sender_sequence_rate_filter
#(
    parameter int MAX_SENDERS = psrf_pkg::MAX_SENDERS_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    // Input channel.
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 mode,
    input  logic [psrf_pkg::SENDER_W-1:0]        sender_index,
    input  logic                                 has_capability,
    input  logic [psrf_pkg::SEQ_W-1:0]           sequence_req,
    input  logic [psrf_pkg::TICK_W-1:0]          now_tick,

    // Result channel.
    output logic                                 done,
    output logic                                 relay,
    output logic [psrf_pkg::VERDICT_W-1:0]       verdict,
    output logic [psrf_pkg::SENDER_W-1:0]        sender_out,

    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [psrf_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [psrf_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [psrf_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    // The sender index field can only reach the first SENDER_COUNT entries, so
    // the table never needs to be deeper than that.
    localparam int Depth  = (MAX_SENDERS < psrf_pkg::SENDER_COUNT) ?
                            MAX_SENDERS : psrf_pkg::SENDER_COUNT;
    localparam int SlotW  = $clog2(Depth);
    localparam int DataW  = psrf_pkg::SEQ_W + psrf_pkg::TICK_W;

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    logic [psrf_pkg::MIN_INT_W-1:0] min_interval_reg;
    logic                           cfg_write;

    assign pready    = 1'b1;
    // There is a single register, so every write lands in it.
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = {{(psrf_pkg::APB_DATA_W - psrf_pkg::MIN_INT_W){1'b0}},
                        min_interval_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= psrf_pkg::MIN_INTERVAL_RESET;
        end
        else if (cfg_write)
        begin
            min_interval_reg <= pwdata[psrf_pkg::MIN_INT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Slot lookup. The sender index folds into the table modulo MAX_SENDERS;
    // the fold is a constant table built at elaboration.
    // ------------------------------------------------------------------
    logic [SlotW-1:0] slot_lut [psrf_pkg::SENDER_COUNT];
    logic [SlotW-1:0] in_slot;

    for (genvar i = 0; i < psrf_pkg::SENDER_COUNT; i++)
    begin : g_slot_lut
        localparam int SlotValue = i % MAX_SENDERS;
        assign slot_lut[i] = SlotW'(SlotValue);
    end

    assign in_slot = slot_lut[sender_index];

    // The block never refuses a word.
    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Stage one: the accepted word, the registered table read and the
    // forwarding path for a write that lands on the same edge as the read.
    // ------------------------------------------------------------------
    logic                          s1_valid_reg;
    logic                          s1_mode_reg;
    logic [psrf_pkg::SENDER_W-1:0] s1_sender_reg;
    logic                          s1_cap_reg;
    logic [psrf_pkg::SEQ_W-1:0]    s1_seq_reg;
    logic [psrf_pkg::TICK_W-1:0]   s1_tick_reg;
    logic [SlotW-1:0]              s1_slot_reg;

    logic [DataW-1:0]              mem [Depth];
    logic [DataW-1:0]              mem_rd_reg;
    logic                          fwd_hit_reg;
    logic [DataW-1:0]              fwd_data_reg;
    logic [Depth-1:0]              valid_reg;

    logic [DataW-1:0]              stored;
    logic                          entry_valid;
    psrf_pkg::entry_t              entry;
    psrf_pkg::verdict_t            s1_verdict;
    logic                          wr_en;
    logic [DataW-1:0]              wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg   <= mode;
            s1_sender_reg <= sender_index;
            s1_cap_reg    <= has_capability;
            s1_seq_reg    <= sequence_req;
            s1_tick_reg   <= now_tick;
            s1_slot_reg   <= in_slot;
        end
    end

    // Sequence and tick storage. Entries are only trusted when their valid
    // bit is set, so the memory itself needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_slot_reg] <= wr_data;
        end
        mem_rd_reg   <= mem[in_slot];
        fwd_data_reg <= wr_data;
    end

    // The read above sees the memory before a write on the same edge, so a
    // relay from the previous word to the same slot is forwarded instead.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= wr_en && (s1_slot_reg == in_slot);
        end
    end

    // Valid bits: set by a relay, cleared by a leave. They are read in the
    // check cycle itself, so they are always current.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_mode_reg == psrf_pkg::MODE_LEAVE)
            begin
                valid_reg[s1_slot_reg] <= 1'b0;
            end
            else if (s1_verdict == psrf_pkg::VERDICT_RELAYED)
            begin
                valid_reg[s1_slot_reg] <= 1'b1;
            end
        end
    end

    // An invalid entry reads as all zero, whatever a cleared or never written
    // entry still holds in the memory.
    assign stored      = fwd_hit_reg ? fwd_data_reg : mem_rd_reg;
    assign entry_valid = valid_reg[s1_slot_reg];
    assign entry.valid = entry_valid;
    assign entry.seq   = entry_valid ? stored[DataW-1 -: psrf_pkg::SEQ_W] : '0;
    assign entry.tick  = entry_valid ? stored[psrf_pkg::TICK_W-1:0] : '0;

    psrf_check u_check
    (
        .leave          (s1_mode_reg == psrf_pkg::MODE_LEAVE),
        .has_capability (s1_cap_reg),
        .sequence_req   (s1_seq_reg),
        .now_tick       (s1_tick_reg),
        .entry          (entry),
        .min_interval   (min_interval_reg),
        .verdict        (s1_verdict)
    );

    // Only a relayed update writes the memory; a leave just drops the valid bit.
    assign wr_en   = s1_valid_reg && (s1_verdict == psrf_pkg::VERDICT_RELAYED);
    assign wr_data = {s1_seq_reg, s1_tick_reg};

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic                           done_reg;
    logic                           relay_reg;
    logic [psrf_pkg::VERDICT_W-1:0] verdict_reg;
    logic [psrf_pkg::SENDER_W-1:0]  sender_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            relay_reg      <= (s1_verdict == psrf_pkg::VERDICT_RELAYED);
            verdict_reg    <= s1_verdict;
            sender_out_reg <= s1_sender_reg;
        end
    end

    assign done       = done_reg;
    assign relay      = relay_reg;
    assign verdict    = verdict_reg;
    assign sender_out = sender_out_reg;

endmodule

### rtl/core/psrf_checker.sv
// Port-level checks on the filter: latency, result pairing and verdict coding.
module psrf_port_checks
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 mode,
    input logic [psrf_pkg::SENDER_W-1:0]        sender_index,
    input logic                                 done,
    input logic                                 relay,
    input logic [psrf_pkg::VERDICT_W-1:0]       verdict,
    input logic [psrf_pkg::SENDER_W-1:0]        sender_out
);

    // Every accepted word gives a result, passing the stage-one register and the result register.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("accepted word gave no result two cycles later");

    // A result always traces back to the matching accepted word.
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2) && (sender_out == $past(sender_index, 2)))
        else $error("result does not match an accepted word");

    // Relay is set for relayed updates and for nothing else.
    a_relay_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (relay == (verdict == psrf_pkg::VERDICT_RELAYED)))
        else $error("relay flag disagrees with verdict");

    // The leave verdict appears exactly for leave words.
    a_leave: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((verdict == psrf_pkg::VERDICT_LEAVE)
                  == ($past(mode, 2) == psrf_pkg::MODE_LEAVE)))
        else $error("leave verdict does not match the word kind");

endmodule

bind per_sender_sequence_rate_filter psrf_port_checks u_psrf_port_checks
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .sender_index (sender_index),
    .done         (done),
    .relay        (relay),
    .verdict      (verdict),
    .sender_out   (sender_out)
);
